// ===== hdl/stdp_pkg.sv =====
// ----------------------------------------------------------------------------
// stdp_pkg: shared types and constants of the STDP synapse engine
// Item formats, register indexes, controller/datapath command and status.
// ----------------------------------------------------------------------------
`default_nettype none

package stdp_pkg;

    typedef enum logic [1:0] {
        REQ_PRE    = 2'd0,
        REQ_POST   = 2'd1,
        REQ_UPDATE = 2'd2,
        REQ_LOAD   = 2'd3
    } req_t;

    typedef struct packed {
        req_t        req_type;
        logic [7:0]  synapse_index;
        logic [31:0] event_time;
        logic [63:0] random_bytes;
        logic [30:0] weight_value;
    } in_item_t;

    typedef struct packed {
        logic [33:0] conductance_increment;
        logic [30:0] current_weight;
    } out_item_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_SITES       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_PROBABILITY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LTP_AMPLITUDE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LTD_AMPLITUDE       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TAU_MS              = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_WEIGHT          = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PLASTIC_MODE        = 3'd6;

    localparam logic [3:0]  RST_RELEASE_SITES = 4'd1;
    localparam logic [8:0]  RST_RELEASE_PROB  = 9'd128;
    localparam logic [30:0] RST_LTP_AMPLITUDE = 31'd1677722;
    localparam logic [30:0] RST_LTD_AMPLITUDE = 31'd2013266;
    localparam logic [15:0] RST_TAU_MS        = 16'd20;
    localparam logic [30:0] RST_MAX_WEIGHT    = 31'd167772160;

    localparam int INDEX_SPAN   = 256;
    localparam int DEN_W        = 36;
    localparam int DVD_W        = 64;
    localparam int SHORT_W      = 36;
    localparam int SERIES_TERMS = 16;
    localparam logic signed [33:0] UPDATE_BIAS = 34'sd17;

    typedef struct packed {
        logic signed [31:0] weight;
        logic signed [31:0] pending;
        logic signed [31:0] ptrace;
        logic signed [31:0] dtrace;
        logic [31:0]        last_pre;
        logic [31:0]        last_post;
    } row_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_ROW,
        OP_PREP,
        OP_DSTART,
        OP_XLAT,
        OP_TMUL,
        OP_TDIV,
        OP_TACC,
        OP_FAC,
        OP_PMUL,
        OP_PRND,
        OP_SMUL,
        OP_SFIN,
        OP_UPD,
        OP_UFIN,
        OP_LDW,
        OP_WRITE,
        OP_RESULT
    } dp_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_READ,
        ST_PREP,
        ST_DSTART,
        ST_DWAIT,
        ST_XLAT,
        ST_TMUL,
        ST_TDIV,
        ST_TWAIT,
        ST_TACC,
        ST_FAC,
        ST_PMUL,
        ST_PRND,
        ST_SMUL,
        ST_SFIN,
        ST_UPD,
        ST_UFIN,
        ST_LDW,
        ST_WRITE,
        ST_PASS
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t op;
    } ctrl_cmd_t;

    typedef struct packed {
        req_t req;
        logic plastic;
        logic idx_bad;
        logic div_busy;
        logic x_ovf;
        logic pow_zero;
        logic pow_last;
        logic k_last;
        logic out_free;
    } dp_status_t;

    // exp(-1) in Q0.30, same truncated series as the runtime unit
    function automatic logic [63:0] exp_one_q30();
        logic [63:0]        term;
        logic signed [63:0] sum;
        term = 64'd1 << 30;
        sum  = 64'sd1 <<< 30;
        for (int k = 1; k <= SERIES_TERMS; k++) begin
            term = ((term * (64'd1 << 30)) >> 30) / 64'(k);
            if (k % 2 == 1) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = '0;
        end
        return sum;
    endfunction

    localparam logic [30:0] E1_Q30 = 31'(exp_one_q30());

endpackage

`default_nettype wire

// ===== hdl/stdp_div.sv =====
// ----------------------------------------------------------------------------
// stdp_div: radix-2 restoring divider
// One quotient bit per cycle; 64 steps for long operands, 36 for short ones.
// ----------------------------------------------------------------------------
`default_nettype none

module stdp_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic                        long_mode,
    input  wire logic [stdp_pkg::DVD_W-1:0]  dividend,
    input  wire logic [stdp_pkg::DEN_W-1:0]  divisor,
    output logic                             busy,
    output logic [stdp_pkg::DVD_W-1:0]       quotient
);
    import stdp_pkg::*;

    localparam logic [6:0] LONG_STEPS  = 7'(DVD_W);
    localparam logic [6:0] SHORT_STEPS = 7'(SHORT_W);

    logic             busy_reg, busy_next;
    logic [6:0]       cnt_reg, cnt_next;
    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_sub;
    logic             ge;

    always_comb begin
        rem_sh    = {rem_reg, dvd_reg[DVD_W-1]};
        rem_sub   = rem_sh - {1'b0, den_reg};
        ge        = rem_sh >= {1'b0, den_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            den_next  = divisor;
            rem_next  = '0;
            quo_next  = '0;
            if (long_mode) begin
                dvd_next = dividend;
                cnt_next = LONG_STEPS;
            end else begin
                dvd_next = {dividend[SHORT_W-1:0], (DVD_W-SHORT_W)'(0)};
                cnt_next = SHORT_STEPS;
            end
        end else if (busy_reg) begin
            rem_next = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], ge};
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== hdl/stdp_dp.sv =====
// ----------------------------------------------------------------------------
// stdp_dp: datapath of the STDP synapse engine
// Config registers, synapse table, shared multiplier, divider, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module stdp_dp #(
    parameter int SYNAPSES        = 256,
    parameter int DEPTH           = 256,
    parameter int AW              = 8,
    parameter int MAX_SITES       = 8,
    parameter int TICKS_PER_MILLI = 1000
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [stdp_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  wire logic [stdp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire stdp_pkg::in_item_t               s_data,
    input  wire stdp_pkg::ctrl_cmd_t              cmd,
    output stdp_pkg::dp_status_t                  status,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output stdp_pkg::out_item_t                   m_data
);
    import stdp_pkg::*;

    // configuration
    logic [3:0]       sites_reg;
    logic [8:0]       prob_reg;
    logic [30:0]      ltp_reg;
    logic [30:0]      ltd_reg;
    logic [15:0]      tau_reg;
    logic [30:0]      wmax_reg;
    logic             plastic_reg;
    logic [DEN_W-1:0] denom_reg;
    logic [15:0]      tau_eff;

    // table
    row_t             mem [DEPTH];
    row_t             mem_q;
    logic [DEPTH-1:0] vld_reg;
    logic             vld_q;
    logic [AW-1:0]    raddr;
    logic [AW-1:0]    waddr;

    // working registers
    in_item_t           item_reg;
    row_t               row_reg;
    logic [33:0]        cond_reg;
    logic [31:0]        dt_reg;
    logic signed [31:0] tr_reg;
    logic               ovf_reg;
    logic [29:0]        f_reg;
    logic [4:0]         n_reg;
    logic signed [33:0] sum_reg;
    logic [30:0]        term_reg;
    logic [4:0]         k_reg;
    logic [30:0]        fac_reg;
    logic [62:0]        prod_reg;
    logic signed [31:0] wnew_reg;
    logic [28:0]        q10_reg;
    logic               m_valid_reg;
    out_item_t          m_data_reg;

    // combinational
    logic [3:0]         sites_eff;
    logic [7:0]         rel;
    logic [3:0]         rel_cnt;
    logic [33:0]        cond_calc;
    logic               idx_bad;
    logic [31:0]        mul_a;
    logic [30:0]        mul_b;
    logic [62:0]        mul_p;
    logic [31:0]        tr_mag;
    logic [62:0]        rnd;
    logic [32:0]        p_mag;
    logic signed [31:0] tr_new;
    logic signed [32:0] pend_sum;
    logic signed [31:0] pend_sat;
    logic [31:0]        c_mag;
    logic [31:0]        c_plus;
    logic [63:0]        c_recip;
    logic [31:0]        c_rest;
    logic signed [33:0] w_sum;
    logic signed [31:0] w_clamp;
    logic               div_start;
    logic               div_long;
    logic [DVD_W-1:0]   div_dvd;
    logic [DEN_W-1:0]   div_den;
    logic               div_busy;
    logic [DVD_W-1:0]   div_q;

    function automatic logic [30:0] weight_out(input logic signed [31:0] w);
        return (w > 0) ? w[30:0] : 31'd0;
    endfunction

    assign tau_eff = (tau_reg == 16'd0) ? 16'd1 : tau_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sites_reg   <= RST_RELEASE_SITES;
            prob_reg    <= RST_RELEASE_PROB;
            ltp_reg     <= RST_LTP_AMPLITUDE;
            ltd_reg     <= RST_LTD_AMPLITUDE;
            tau_reg     <= RST_TAU_MS;
            wmax_reg    <= RST_MAX_WEIGHT;
            plastic_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_RELEASE_SITES:       sites_reg   <= cfg_wdata[3:0];
                REG_RELEASE_PROBABILITY: prob_reg    <= cfg_wdata[8:0];
                REG_LTP_AMPLITUDE:       ltp_reg     <= cfg_wdata;
                REG_LTD_AMPLITUDE:       ltd_reg     <= cfg_wdata;
                REG_TAU_MS:              tau_reg     <= cfg_wdata[15:0];
                REG_MAX_WEIGHT:          wmax_reg    <= cfg_wdata;
                REG_PLASTIC_MODE:        plastic_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        denom_reg <= DEN_W'(TICKS_PER_MILLI) * DEN_W'(tau_eff);
    end

    // table storage
    assign raddr = s_data.synapse_index[AW-1:0];
    assign waddr = item_reg.synapse_index[AW-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_WRITE) begin
            mem[waddr] <= row_reg;
        end
        if (cmd.op == OP_LOAD) begin
            mem_q <= mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (cmd.op == OP_WRITE) begin
            vld_reg[waddr] <= 1'b1;
        end
    end

    // release sites
    always_comb begin
        sites_eff = (sites_reg > 4'(MAX_SITES)) ? 4'(MAX_SITES) : sites_reg;
        rel_cnt   = '0;
        for (int i = 0; i < 8; i++) begin
            rel[i]  = (4'(i) < sites_eff) &&
                      ({1'b0, item_reg.random_bytes[8*i +: 8]} < prob_reg);
            rel_cnt = rel_cnt + 4'(rel[i]);
        end
        cond_calc = (row_reg.weight > 0) ?
                    34'(rel_cnt) * 34'(row_reg.weight[30:0]) : 34'd0;
    end

    assign idx_bad = {24'd0, item_reg.synapse_index} >= 32'(SYNAPSES);

    // shared multiplier
    assign tr_mag = tr_reg[31] ? (~tr_reg + 32'd1) : tr_reg;

    always_comb begin
        unique case (cmd.op)
            OP_TMUL: begin
                mul_a = {1'b0, term_reg};
                mul_b = {1'b0, f_reg};
            end
            OP_PMUL: begin
                mul_a = {1'b0, fac_reg};
                mul_b = E1_Q30;
            end
            default: begin
                mul_a = tr_mag;
                mul_b = fac_reg;
            end
        endcase
    end

    assign mul_p = 63'(mul_a) * 63'(mul_b);

    // rounding, trace and pending saturation
    always_comb begin
        rnd    = prod_reg + (63'd1 << 29);
        p_mag  = rnd[62:30];
        if (tr_reg[31]) begin
            tr_new = ~p_mag[31:0] + 32'd1;
        end else begin
            tr_new = p_mag[31] ? 32'sh7FFFFFFF : p_mag[31:0];
        end
        pend_sum = 33'(row_reg.pending) + 33'(tr_new);
        if (pend_sum[32] != pend_sum[31]) begin
            pend_sat = pend_sum[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end else begin
            pend_sat = pend_sum[31:0];
        end
    end

    // weight update terms
    // (9c+5)/10 = c - (c+4)/10; the divide by ten is a reciprocal multiply
    always_comb begin
        c_mag    = row_reg.pending[31] ? (~row_reg.pending + 32'd1) : row_reg.pending;
        c_plus   = c_mag + 32'd4;
        c_recip  = 64'(c_plus) * 64'(32'hCCCCCCCD);
        c_rest   = c_mag - {3'd0, q10_reg};
        w_sum    = 34'(row_reg.weight) + UPDATE_BIAS + 34'(row_reg.pending);
        if (w_sum < 0) begin
            w_clamp = '0;
        end else if (w_sum > $signed({3'd0, wmax_reg})) begin
            w_clamp = {1'b0, wmax_reg};
        end else begin
            w_clamp = w_sum[31:0];
        end
    end

    // divider
    always_comb begin
        div_start = 1'b0;
        div_long  = 1'b0;
        div_dvd   = {2'd0, dt_reg, 30'd0};
        div_den   = denom_reg;
        unique case (cmd.op)
            OP_DSTART: begin
                div_start = 1'b1;
                div_long  = 1'b1;
            end
            OP_TDIV: begin
                div_start = 1'b1;
                div_dvd   = DVD_W'(prod_reg[62:30]);
                div_den   = DEN_W'(k_reg);
            end
            default: ;
        endcase
    end

    stdp_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .long_mode (div_long),
        .dividend  (div_dvd),
        .divisor   (div_den),
        .busy      (div_busy),
        .quotient  (div_q)
    );

    // working registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                item_reg <= s_data;
                vld_q    <= vld_reg[raddr];
            end
            OP_ROW: begin
                row_reg <= vld_q ? mem_q : '0;
            end
            OP_PREP: begin
                cond_reg <= (item_reg.req_type == REQ_PRE) ? cond_calc : 34'd0;
                if (item_reg.req_type == REQ_PRE) begin
                    dt_reg <= item_reg.event_time - row_reg.last_post;
                    tr_reg <= row_reg.dtrace;
                end else begin
                    dt_reg <= item_reg.event_time - row_reg.last_pre;
                    tr_reg <= row_reg.ptrace;
                end
            end
            OP_XLAT: begin
                ovf_reg  <= |div_q[63:35];
                n_reg    <= (|div_q[63:35]) ? 5'd0 : div_q[34:30];
                f_reg    <= div_q[29:0];
                sum_reg  <= 34'sd1 <<< 30;
                term_reg <= 31'd1 << 30;
                k_reg    <= 5'd1;
            end
            OP_TMUL, OP_PMUL, OP_SMUL: begin
                prod_reg <= mul_p;
            end
            OP_TACC: begin
                term_reg <= div_q[30:0];
                sum_reg  <= k_reg[0] ? (sum_reg - 34'(div_q[30:0]))
                                     : (sum_reg + 34'(div_q[30:0]));
                k_reg    <= k_reg + 5'd1;
            end
            OP_FAC: begin
                fac_reg <= (ovf_reg || sum_reg < 0) ? 31'd0 : sum_reg[30:0];
            end
            OP_PRND: begin
                fac_reg <= rnd[60:30];
                n_reg   <= n_reg - 5'd1;
            end
            OP_SFIN: begin
                row_reg.pending <= pend_sat;
                if (item_reg.req_type == REQ_PRE) begin
                    row_reg.dtrace   <= tr_new;
                    row_reg.ptrace   <= {1'b0, ltp_reg};
                    row_reg.last_pre <= item_reg.event_time;
                end else begin
                    row_reg.ptrace    <= tr_new;
                    row_reg.dtrace    <= ~{1'b0, ltd_reg} + 32'd1;
                    row_reg.last_post <= item_reg.event_time;
                end
            end
            OP_UPD: begin
                wnew_reg <= w_clamp;
                q10_reg  <= c_recip[63:35];
            end
            OP_UFIN: begin
                row_reg.weight  <= wnew_reg;
                row_reg.pending <= row_reg.pending[31] ? (~c_rest + 32'd1) : c_rest;
            end
            OP_LDW: begin
                row_reg <= {{1'b0, item_reg.weight_value}, 160'd0};
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.op == OP_WRITE || cmd.op == OP_RESULT) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_WRITE || cmd.op == OP_RESULT) begin
            if (idx_bad) begin
                m_data_reg <= '0;
            end else begin
                m_data_reg.conductance_increment <= cond_reg;
                m_data_reg.current_weight        <= weight_out(row_reg.weight);
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        status.req      = item_reg.req_type;
        status.plastic  = plastic_reg;
        status.idx_bad  = idx_bad;
        status.div_busy = div_busy;
        status.x_ovf    = |div_q[63:35];
        status.pow_zero = n_reg == 5'd0;
        status.pow_last = n_reg == 5'd1;
        status.k_last   = k_reg == 5'(SERIES_TERMS);
        status.out_free = !m_valid_reg || m_ready;
    end

endmodule

`default_nettype wire

// ===== hdl/stdp_ctrl.sv =====
// ----------------------------------------------------------------------------
// stdp_ctrl: request sequencer of the STDP synapse engine
// Steps the datapath through read, decay, update and write-back of one item.
// ----------------------------------------------------------------------------
`default_nettype none

module stdp_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire stdp_pkg::dp_status_t status,
    output stdp_pkg::ctrl_cmd_t       cmd
);
    import stdp_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.op     = OP_ROW;
                state_next = ST_PREP;
            end
            ST_PREP: begin
                cmd.op = OP_PREP;
                if (status.idx_bad || (status.req != REQ_LOAD && !status.plastic)) begin
                    state_next = ST_PASS;
                end else if (status.req == REQ_LOAD) begin
                    state_next = ST_LDW;
                end else if (status.req == REQ_UPDATE) begin
                    state_next = ST_UPD;
                end else begin
                    state_next = ST_DSTART;
                end
            end
            ST_DSTART: begin
                cmd.op     = OP_DSTART;
                state_next = ST_DWAIT;
            end
            ST_DWAIT: begin
                if (!status.div_busy) begin
                    state_next = ST_XLAT;
                end
            end
            ST_XLAT: begin
                cmd.op     = OP_XLAT;
                state_next = status.x_ovf ? ST_FAC : ST_TMUL;
            end
            ST_TMUL: begin
                cmd.op     = OP_TMUL;
                state_next = ST_TDIV;
            end
            ST_TDIV: begin
                cmd.op     = OP_TDIV;
                state_next = ST_TWAIT;
            end
            ST_TWAIT: begin
                if (!status.div_busy) begin
                    state_next = ST_TACC;
                end
            end
            ST_TACC: begin
                cmd.op     = OP_TACC;
                state_next = status.k_last ? ST_FAC : ST_TMUL;
            end
            ST_FAC: begin
                cmd.op     = OP_FAC;
                state_next = status.pow_zero ? ST_SMUL : ST_PMUL;
            end
            ST_PMUL: begin
                cmd.op     = OP_PMUL;
                state_next = ST_PRND;
            end
            ST_PRND: begin
                cmd.op     = OP_PRND;
                state_next = status.pow_last ? ST_SMUL : ST_PMUL;
            end
            ST_SMUL: begin
                cmd.op     = OP_SMUL;
                state_next = ST_SFIN;
            end
            ST_SFIN: begin
                cmd.op     = OP_SFIN;
                state_next = ST_WRITE;
            end
            ST_UPD: begin
                cmd.op     = OP_UPD;
                state_next = ST_UFIN;
            end
            ST_UFIN: begin
                cmd.op     = OP_UFIN;
                state_next = ST_WRITE;
            end
            ST_LDW: begin
                cmd.op     = OP_LDW;
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                if (status.out_free) begin
                    cmd.op     = OP_WRITE;
                    state_next = ST_IDLE;
                end
            end
            ST_PASS: begin
                if (status.out_free) begin
                    cmd.op     = OP_RESULT;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/stdp_synapse_engine.sv =====
// ----------------------------------------------------------------------------
// stdp_synapse_engine: plastic synapse table with release and pair-based STDP
// One item at a time; the result register lets the next item in while the
// previous result waits.
// ----------------------------------------------------------------------------
// Paths: non-plastic and bad-index items, loads and updates skip the divider;
//   plastic spikes run dt/tau on the one-bit-per-cycle divider, then 16 series
//   terms that each use it, then a multiply and a rounding step per whole tau
//   elapsed; the series and these steps are skipped when dt is 32 tau or more.
// Stalls: a waiting result holds the next item at its final result step.
// Reset: synchronous, active low; table entries read as zero until written.
`default_nettype none

module stdp_synapse_engine #(
    parameter int SYNAPSES        = 256,
    parameter int MAX_SITES       = 8,
    parameter int TICKS_PER_MILLI = 1000
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [stdp_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  wire logic [stdp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire stdp_pkg::in_item_t               s_data,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output stdp_pkg::out_item_t                   m_data
);
    import stdp_pkg::*;

    localparam int DEPTH = (SYNAPSES < INDEX_SPAN) ? SYNAPSES : INDEX_SPAN;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    stdp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    stdp_dp #(
        .SYNAPSES        (SYNAPSES),
        .DEPTH           (DEPTH),
        .AW              (AW),
        .MAX_SITES       (MAX_SITES),
        .TICKS_PER_MILLI (TICKS_PER_MILLI)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("engine still ready after taking an item");

    a_idle_div: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !status.div_busy)
        else $error("divider busy while engine idle");

    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.op == OP_WRITE || cmd.op == OP_RESULT))
        else $error("result raised without a finishing step");

endmodule

`default_nettype wire

// ===== tb/stdp_synapse_engine_tb.sv =====
// ----------------------------------------------------------------------------
// stdp_synapse_engine_tb: self-checking bench for the STDP synapse engine
// Drives directed and random pre/post/update/load items through the synapse
// table, predicts release sums and weights with a cycle-free model of the
// trace and weight math, and checks every result item in order.
// ----------------------------------------------------------------------------
`default_nettype none

module stdp_synapse_engine_tb;

    import stdp_pkg::*;

    localparam int      CYCLE_LIMIT = 4000000;
    localparam longint  ONE_Q30     = 64'd1 << 30;
    localparam longint  HALF_Q30    = 64'd1 << 29;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_item_t              s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_data;

    stdp_synapse_engine DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // synapse table shadow
    logic [3:0]         sites_cfg;
    logic [8:0]         prob_cfg;
    logic [30:0]        ltp_cfg;
    logic [30:0]        ltd_cfg;
    logic [15:0]        tau_cfg;
    logic [30:0]        maxw_cfg;
    logic               plastic_cfg;
    logic signed [31:0] syn_weight [256];
    logic signed [31:0] syn_pending [256];
    logic signed [31:0] syn_ptrace [256];
    logic signed [31:0] syn_dtrace [256];
    logic [31:0]        syn_pre_t [256];
    logic [31:0]        syn_post_t [256];

    in_item_t  req_q [$];
    out_item_t expected_q [$];
    bit        failed = 1'b0;
    bit        quiet = 1'b0;
    int        idle_pct = 0;
    int        hold_reqs = 0;
    int        hold_seen = 0;
    int        send_gap = 0;
    int        recv_gap = 0;
    int        cycles = 0;
    logic [31:0] tick = '0;

    function automatic logic [63:0] exp_neg(input logic [63:0] f);
        logic signed [63:0] acc;
        logic [63:0]        term;
        acc  = ONE_Q30;
        term = ONE_Q30;
        for (int k = 1; k <= 16; k++) begin
            term = ((term * f) >> 30) / 64'(k);
            if (k % 2 == 1) begin
                acc = acc - $signed(term);
            end else begin
                acc = acc + $signed(term);
            end
        end
        return (acc < 0) ? 64'd0 : acc;
    endfunction

    function automatic logic [63:0] decay_of(input logic [31:0] dt);
        logic [63:0] den;
        logic [63:0] x;
        logic [63:0] n;
        logic [63:0] fac;
        logic [63:0] e1;
        den = 64'd1000 * ((tau_cfg == 0) ? 64'd1 : 64'(tau_cfg));
        x   = ({32'd0, dt} << 30) / den;
        n   = x >> 30;
        if (n >= 32) begin
            return 64'd0;
        end
        fac = exp_neg(x & (ONE_Q30 - 1));
        e1  = exp_neg(ONE_Q30);
        for (int i = 0; i < n; i++) begin
            fac = (fac * e1 + HALF_Q30) >> 30;
        end
        return fac;
    endfunction

    function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] decayed_trace(input logic signed [31:0] tr,
                                                         input logic [63:0] fac);
        logic [63:0]        mag;
        logic signed [63:0] p;
        mag = (tr < 0) ? 64'(-64'(tr)) : 64'(tr);
        p   = (mag * fac + HALF_Q30) >> 30;
        if (tr < 0) begin
            p = -p;
        end
        return clip32(p);
    endfunction

    function automatic out_item_t synapse_response(input in_item_t it);
        out_item_t          r;
        int                 idx;
        int                 n_sites;
        logic [33:0]        cond;
        logic signed [31:0] tr;
        logic signed [63:0] w;
        logic [63:0]        mag;
        logic               neg;
        idx  = it.synapse_index;
        cond = '0;
        case (it.req_type)
            REQ_PRE: begin
                n_sites = (sites_cfg > 8) ? 8 : sites_cfg;
                for (int i = 0; i < n_sites; i++) begin
                    if ({1'b0, it.random_bytes[8*i +: 8]} < prob_cfg && syn_weight[idx] > 0) begin
                        cond = cond + 34'(syn_weight[idx]);
                    end
                end
                if (plastic_cfg) begin
                    tr = decayed_trace(syn_dtrace[idx],
                                       decay_of(it.event_time - syn_post_t[idx]));
                    syn_dtrace[idx]  = tr;
                    syn_pending[idx] = clip32(64'(syn_pending[idx]) + 64'(tr));
                    syn_ptrace[idx]  = {1'b0, ltp_cfg};
                    syn_pre_t[idx]   = it.event_time;
                end
            end
            REQ_POST: begin
                if (plastic_cfg) begin
                    tr = decayed_trace(syn_ptrace[idx],
                                       decay_of(it.event_time - syn_pre_t[idx]));
                    syn_ptrace[idx]  = tr;
                    syn_pending[idx] = clip32(64'(syn_pending[idx]) + 64'(tr));
                    syn_dtrace[idx]  = -$signed({1'b0, ltd_cfg});
                    syn_post_t[idx]  = it.event_time;
                end
            end
            REQ_UPDATE: begin
                if (plastic_cfg) begin
                    w = 64'(syn_weight[idx]) + 64'sd17 + 64'(syn_pending[idx]);
                    if (w < 0) begin
                        w = 0;
                    end else if (w > 64'(maxw_cfg)) begin
                        w = 64'(maxw_cfg);
                    end
                    syn_weight[idx] = w[31:0];
                    neg = syn_pending[idx] < 0;
                    mag = neg ? 64'(-64'(syn_pending[idx])) : 64'(syn_pending[idx]);
                    mag = (mag * 9 + 5) / 10;
                    syn_pending[idx] = neg ? -$signed(mag[31:0]) : mag[31:0];
                end
            end
            default: begin
                syn_weight[idx]  = {1'b0, it.weight_value};
                syn_pending[idx] = '0;
                syn_ptrace[idx]  = '0;
                syn_dtrace[idx]  = '0;
                syn_pre_t[idx]   = '0;
                syn_post_t[idx]  = '0;
            end
        endcase
        r.conductance_increment = cond;
        r.current_weight = (syn_weight[idx] > 0) ? syn_weight[idx][30:0] : '0;
        return r;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_valid <= 1'b0;
            end else if (!quiet && $urandom_range(99) < idle_pct) begin
                send_gap <= $urandom_range(0, 4);
                s_valid <= 1'b0;
            end else if (req_q.size() > 0) begin
                s_data <= req_q.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            m_ready <= 1'b0;
        end else if (hold_seen != hold_reqs) begin
            hold_seen <= hold_reqs;
            recv_gap <= 4000;
            m_ready <= 1'b0;
        end else if (!quiet && $urandom_range(99) < idle_pct) begin
            recv_gap <= $urandom_range(0, 4);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // monitor and scoreboard
    always @(posedge aclk) begin
        out_item_t want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected item %h", $time, m_data);
                    failed = 1'b1;
                end else begin
                    want = expected_q.pop_front();
                    if (want.conductance_increment != m_data.conductance_increment) begin
                        $display("%0t: conductance exp %h got %h", $time,
                                 want.conductance_increment, m_data.conductance_increment);
                        failed = 1'b1;
                    end
                    if (want.current_weight != m_data.current_weight) begin
                        $display("%0t: weight exp %h got %h", $time,
                                 want.current_weight, m_data.current_weight);
                        failed = 1'b1;
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_q.insert(expected_q.size(), synapse_response(s_data));
            end
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_RELEASE_SITES:       sites_cfg = cfg_wdata[3:0];
                    REG_RELEASE_PROBABILITY: prob_cfg = cfg_wdata[8:0];
                    REG_LTP_AMPLITUDE:       ltp_cfg = cfg_wdata;
                    REG_LTD_AMPLITUDE:       ltd_cfg = cfg_wdata;
                    REG_TAU_MS:              tau_cfg = cfg_wdata[15:0];
                    REG_MAX_WEIGHT:          maxw_cfg = cfg_wdata;
                    REG_PLASTIC_MODE:        plastic_cfg = cfg_wdata[0];
                    default: ;
                endcase
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] a, input logic [30:0] d);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= a;
        cfg_wdata <= d;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_config(input int sites, input int prob, input logic [30:0] ltp,
                              input logic [30:0] ltd, input int tau,
                              input logic [30:0] maxw, input bit plastic);
        write_reg(REG_RELEASE_SITES, 31'(sites));
        write_reg(REG_RELEASE_PROBABILITY, 31'(prob));
        write_reg(REG_LTP_AMPLITUDE, ltp);
        write_reg(REG_LTD_AMPLITUDE, ltd);
        write_reg(REG_TAU_MS, 31'(tau));
        write_reg(REG_MAX_WEIGHT, maxw);
        write_reg(REG_PLASTIC_MODE, 31'(plastic));
    endtask

    task automatic send(input req_t kind, input int idx, input logic [31:0] t,
                        input logic [63:0] rnd, input logic [30:0] w);
        in_item_t it;
        it.req_type      = kind;
        it.synapse_index = idx[7:0];
        it.event_time    = t;
        it.random_bytes  = rnd;
        it.weight_value  = w;
        req_q.insert(req_q.size(), it);
    endtask

    task automatic drain();
        do begin
            @(posedge aclk);
        end while (req_q.size() != 0 || s_valid || expected_q.size() != 0);
        repeat (10) @(posedge aclk);
    endtask

    task automatic random_items(input int count);
        int    idx;
        int    pick;
        int    span;
        req_t  kind;
        for (int i = 0; i < count; i++) begin
            idx  = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(7);
            pick = $urandom_range(99);
            span = 1000 * ((tau_cfg == 0) ? 1 : tau_cfg);
            if (pick < 35) begin
                kind = REQ_PRE;
            end else if (pick < 70) begin
                kind = REQ_POST;
            end else if (pick < 90) begin
                kind = REQ_UPDATE;
            end else begin
                kind = REQ_LOAD;
            end
            pick = $urandom_range(99);
            if (pick < 70) begin
                tick = tick + $urandom_range(0, 2 * span);
            end else if (pick < 90) begin
                tick = tick + $urandom_range(0, 40 * span);
            end else begin
                tick = $urandom;
            end
            send(kind, idx, tick, {$urandom, $urandom},
                 ($urandom_range(3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 1 << 28)));
        end
    endtask

    initial begin
        sites_cfg   = RST_RELEASE_SITES;
        prob_cfg    = RST_RELEASE_PROB;
        ltp_cfg     = RST_LTP_AMPLITUDE;
        ltd_cfg     = RST_LTD_AMPLITUDE;
        tau_cfg     = RST_TAU_MS;
        maxw_cfg    = RST_MAX_WEIGHT;
        plastic_cfg = 1'b1;
        for (int i = 0; i < 256; i++) begin
            syn_weight[i]  = '0;
            syn_pending[i] = '0;
            syn_ptrace[i]  = '0;
            syn_dtrace[i]  = '0;
            syn_pre_t[i]   = '0;
            syn_post_t[i]  = '0;
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // directed: extremes at reset settings
        send(REQ_LOAD, 0, 0, 0, 31'h7FFFFFFF);
        send(REQ_PRE, 0, 0, 64'd0, 0);
        send(REQ_LOAD, 255, 0, 0, 0);
        send(REQ_PRE, 255, 32'hFFFFFFFF, {64{1'b1}}, 31'h7FFFFFFF);
        send(REQ_POST, 0, 5000, 0, 0);
        send(REQ_UPDATE, 0, 0, 0, 0);
        send(REQ_PRE, 0, 5000, 64'h7F7F7F7F7F7F7F7F, 0);
        send(REQ_POST, 0, 32'hFFFFFFFF, 0, 0);
        send(REQ_UPDATE, 0, 0, 0, 0);
        drain();
        // sites past the limit, certain release, zero tau, pending saturation
        set_config(15, 511, 31'h7FFFFFFF, 31'h7FFFFFFF, 0, 31'h7FFFFFFF, 1);
        send(REQ_PRE, 0, 100, {64{1'b1}}, 0);
        send(REQ_PRE, 1, 100, 0, 0);
        send(REQ_POST, 1, 100, 0, 0);
        send(REQ_PRE, 1, 100, 0, 0);
        send(REQ_POST, 1, 100, 0, 0);
        send(REQ_UPDATE, 1, 0, 0, 0);
        send(REQ_POST, 2, 50, 0, 0);
        send(REQ_PRE, 2, 50, 0, 0);
        send(REQ_POST, 2, 50, 0, 0);
        send(REQ_PRE, 2, 50, 0, 0);
        send(REQ_UPDATE, 2, 0, 0, 0);
        drain();
        set_config(2, 0, 0, 0, 65535, 0, 0);
        send(REQ_PRE, 0, 7, 0, 0);
        send(REQ_POST, 0, 9, 0, 0);
        send(REQ_UPDATE, 0, 0, 0, 0);
        send(REQ_LOAD, 3, 0, 0, 31'h12345678);
        drain();

        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: set_config(1, 128, RST_LTP_AMPLITUDE, RST_LTD_AMPLITUDE, 20,
                              RST_MAX_WEIGHT, 1);
                1: set_config(8, 256, 31'($urandom_range(0, 1 << 27)),
                              31'($urandom_range(0, 1 << 27)), 1, 31'h7FFFFFFF, 1);
                2: set_config(0, 0, 31'h7FFFFFFF, 31'h7FFFFFFF, 65535, 0, 1);
                3: set_config($urandom_range(0, 15), $urandom_range(0, 511), 31'($urandom),
                              31'($urandom), $urandom_range(1, 100), 31'($urandom), 1);
                4: set_config(4, 200, 31'($urandom), 31'($urandom), 5, 31'($urandom), 0);
                5: set_config(15, 511, 31'h7FFFFFFF, 31'h7FFFFFFF, 0, 31'h7FFFFFFF, 1);
                default: set_config(3, 100, 31'($urandom_range(0, 1 << 26)),
                                    31'($urandom_range(0, 1 << 26)), 10,
                                    31'($urandom_range(0, 1 << 30)), 1);
            endcase
            idle_pct = (ph % 3 == 2) ? 0 : $urandom_range(10, 40);
            quiet    = (ph == 6);
            if (ph == 1) begin
                hold_reqs = hold_reqs + 1;
            end
            random_items(225);
            drain();
        end

        repeat (50) @(posedge aclk);
        if (!failed && expected_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

`default_nettype wire
